@@ hdl/pidc_pkg.sv @@
// pidc_pkg: shared widths, command codes and controller/datapath structs
// for the clamped pid controller; depends on nothing
package pidc_pkg;

    localparam int ERR_W     = 32;
    localparam int DT_W      = 16;
    localparam int DRV_W     = 27;
    localparam int TMR_W     = 32;
    localparam int INT_W     = 64;
    localparam int BAND_W    = 31;
    localparam int TERM_W    = 62;
    localparam int MA_W      = 33;
    localparam int MB_W      = 32;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int IFULL_W   = 96;
    localparam int DIVD_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int TERM_CAP_SH = 60;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_BAND = 2'd3;

    // input command codes
    localparam logic CMD_UPDATE      = 1'b0;
    localparam logic CMD_TIMER_RESET = 1'b1;

    // shared multiplier operand selects
    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_D    = 3'd1;
    localparam logic [2:0] MUL_INC  = 3'd2;
    localparam logic [2:0] MUL_P    = 3'd3;
    localparam logic [2:0] MUL_ILO  = 3'd4;
    localparam logic [2:0] MUL_IHI  = 3'd5;

    typedef struct packed {
        logic       load;
        logic [2:0] mul_sel;
        logic       div_start;
        logic       integ_upd;
        logic       p_store;
        logic       ilo_store;
        logic       i_join;
        logic       i_cap;
        logic       d_take;
        logic       sum;
        logic       commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_timer_reset;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

@@ hdl/pidc_div.sv @@
// pidc_div: unsigned 64 by 16 restoring divider, two quotient bits a cycle
// depends on pidc_pkg
module pidc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pidc_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [pidc_pkg::DT_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [pidc_pkg::DIVD_W-1:0]  o_quotient
);

    localparam int STEPS = pidc_pkg::DIVD_W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam int DW    = pidc_pkg::DT_W;

    logic [pidc_pkg::DIVD_W-1:0] r_work, n_work;
    logic [DW-1:0]               r_rem, n_rem;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [DW:0]   rem_a, rem_b, dvs;
    logic [DW-1:0] rem_a1;
    logic          q1, q2;

    // two dependent subtract steps per cycle
    always_comb begin
        dvs   = {1'b0, i_divisor};
        rem_a = {r_rem, r_work[pidc_pkg::DIVD_W-1]};
        if (rem_a >= dvs) begin
            rem_a1 = DW'(rem_a - dvs);
            q1     = 1'b1;
        end else begin
            rem_a1 = rem_a[DW-1:0];
            q1     = 1'b0;
        end
        rem_b = {rem_a1, r_work[pidc_pkg::DIVD_W-2]};
        if (rem_b >= dvs) begin
            n_rem = DW'(rem_b - dvs);
            q2    = 1'b1;
        end else begin
            n_rem = rem_b[DW-1:0];
            q2    = 1'b0;
        end
        n_work = {r_work[pidc_pkg::DIVD_W-3:0], q1, q2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule

@@ hdl/pidc_dp.sv @@
// pidc_dp: datapath with gain registers, controller state, shared multiplier,
// divider instance and output register; depends on pidc_pkg and pidc_div
module pidc_dp #(
    parameter int OUTPUT_LIMIT = 1000,
    parameter int FRAC_BITS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pidc_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                             i_command,
    input  logic signed [pidc_pkg::ERR_W-1:0] i_error,
    input  logic [pidc_pkg::DT_W-1:0]        i_delta_t,
    input  pidc_pkg::t_dp_cmd                i_cmd,
    output pidc_pkg::t_dp_status             o_status,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [pidc_pkg::DRV_W-1:0] o_drive,
    output logic [pidc_pkg::TMR_W-1:0]       o_time_since_set,
    output logic [pidc_pkg::TMR_W-1:0]       o_time_in_band,
    output logic                             o_in_band
);

    localparam int TW = pidc_pkg::TERM_W;
    localparam logic signed [TW-1:0] LIM     = TW'(OUTPUT_LIMIT) << FRAC_BITS;
    localparam logic signed [TW-1:0] NEG_LIM = -LIM;
    localparam logic [pidc_pkg::IFULL_W-1:0] I_CAP_WIDE =
        pidc_pkg::IFULL_W'(1) << pidc_pkg::TERM_CAP_SH;
    localparam logic [TW-1:0] I_CAP = TW'(1) << pidc_pkg::TERM_CAP_SH;
    localparam logic signed [pidc_pkg::INT_W-1:0] INT_MAX = {1'b0, {(pidc_pkg::INT_W-1){1'b1}}};
    localparam logic signed [pidc_pkg::INT_W-1:0] INT_MIN = {1'b1, {(pidc_pkg::INT_W-1){1'b0}}};

    // configuration
    logic signed [pidc_pkg::ERR_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [pidc_pkg::BAND_W-1:0]       r_band;

    // persistent state
    logic signed [pidc_pkg::ERR_W-1:0] r_prev_err;
    logic signed [pidc_pkg::INT_W-1:0] r_integ, n_integ;
    logic [pidc_pkg::TMR_W-1:0]        r_set_tmr, r_band_tmr, n_set_tmr, n_band_tmr;
    logic [pidc_pkg::DRV_W-1:0]        r_last_drive;

    // per-word working registers
    logic                              r_cmd_bit;
    logic signed [pidc_pkg::ERR_W-1:0] r_err;
    logic [pidc_pkg::DT_W-1:0]         r_dt;
    logic [pidc_pkg::PROD_W-1:0]       r_prod;
    logic [pidc_pkg::INT_W-1:0]        r_ilo;
    logic [pidc_pkg::IFULL_W-1:0]      r_ifull;
    logic signed [TW-1:0]              r_p, r_i, r_d, n_p, n_i, n_d;
    logic [pidc_pkg::DRV_W-1:0]        r_drive, n_drive;

    // output register
    logic                              r_out_valid;
    logic signed [pidc_pkg::DRV_W-1:0] r_o_drive;
    logic [pidc_pkg::TMR_W-1:0]        r_o_set, r_o_band;
    logic                              r_o_in_band;

    logic [pidc_pkg::ERR_W-1:0]   err_mag, gp_mag, gi_mag, gd_mag;
    logic signed [pidc_pkg::ERR_W:0] diff;
    logic [pidc_pkg::ERR_W:0]     diff_mag;
    logic [pidc_pkg::INT_W-1:0]   integ_mag;
    logic [pidc_pkg::MA_W-1:0]    mul_a;
    logic [pidc_pkg::MB_W-1:0]    mul_b;
    logic [pidc_pkg::PROD_W-1:0]  mul_p;
    logic [pidc_pkg::INT_W-1:0]   inc;
    logic signed [pidc_pkg::INT_W:0] integ_sum;
    logic [TW-1:0]                p_mag, i_mag, d_mag;
    logic [pidc_pkg::IFULL_W-1:0] i_shift;
    logic signed [TW-1:0]         sum;
    logic                         band_hit;
    logic [pidc_pkg::TMR_W:0]     set_add, band_add;
    logic                         div_done;
    logic [pidc_pkg::DIVD_W-1:0]  div_quot;

    // magnitudes of the signed operands
    always_comb begin
        err_mag   = r_err[pidc_pkg::ERR_W-1] ? (~r_err + 1'b1) : r_err;
        gp_mag    = r_gain_p[pidc_pkg::ERR_W-1] ? (~r_gain_p + 1'b1) : r_gain_p;
        gi_mag    = r_gain_i[pidc_pkg::ERR_W-1] ? (~r_gain_i + 1'b1) : r_gain_i;
        gd_mag    = r_gain_d[pidc_pkg::ERR_W-1] ? (~r_gain_d + 1'b1) : r_gain_d;
        diff      = {r_err[pidc_pkg::ERR_W-1], r_err}
                  - {r_prev_err[pidc_pkg::ERR_W-1], r_prev_err};
        diff_mag  = diff[pidc_pkg::ERR_W] ? (~diff + 1'b1) : diff;
        integ_mag = r_integ[pidc_pkg::INT_W-1] ? (~r_integ + 1'b1) : r_integ;
    end

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            pidc_pkg::MUL_D: begin
                mul_a = diff_mag;
                mul_b = gd_mag;
            end
            pidc_pkg::MUL_INC: begin
                mul_a = {1'b0, err_mag};
                mul_b = {{(pidc_pkg::MB_W-pidc_pkg::DT_W){1'b0}}, r_dt};
            end
            pidc_pkg::MUL_P: begin
                mul_a = {1'b0, err_mag};
                mul_b = gp_mag;
            end
            pidc_pkg::MUL_ILO: begin
                mul_a = {1'b0, integ_mag[31:0]};
                mul_b = gi_mag;
            end
            pidc_pkg::MUL_IHI: begin
                mul_a = {1'b0, integ_mag[63:32]};
                mul_b = gi_mag;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // integral update, term scaling, sum and clamp
    always_comb begin
        inc = r_err[pidc_pkg::ERR_W-1] ? (~{16'b0, r_prod[47:0]} + 1'b1)
                                       : {16'b0, r_prod[47:0]};
        integ_sum = {r_integ[pidc_pkg::INT_W-1], r_integ}
                  + {inc[pidc_pkg::INT_W-1], inc};
        if (integ_sum[pidc_pkg::INT_W] != integ_sum[pidc_pkg::INT_W-1]) begin
            n_integ = integ_sum[pidc_pkg::INT_W] ? INT_MIN : INT_MAX;
        end else begin
            n_integ = integ_sum[pidc_pkg::INT_W-1:0];
        end

        p_mag = TW'(r_prod >> FRAC_BITS);
        n_p   = (r_gain_p[pidc_pkg::ERR_W-1] != r_err[pidc_pkg::ERR_W-1])
              ? (~p_mag + 1'b1) : p_mag;

        i_shift = r_ifull >> FRAC_BITS;
        i_mag   = (i_shift > I_CAP_WIDE) ? I_CAP : i_shift[TW-1:0];
        n_i     = (r_gain_i[pidc_pkg::ERR_W-1] != r_integ[pidc_pkg::INT_W-1])
                ? (~i_mag + 1'b1) : i_mag;

        d_mag = TW'(div_quot >> FRAC_BITS);
        if (r_dt == '0) begin
            n_d = '0;
        end else if (r_gain_d[pidc_pkg::ERR_W-1] != diff[pidc_pkg::ERR_W]) begin
            n_d = ~d_mag + 1'b1;
        end else begin
            n_d = d_mag;
        end

        sum = r_p + r_i + r_d;
        if (sum > LIM) begin
            n_drive = LIM[pidc_pkg::DRV_W-1:0];
        end else if (sum < NEG_LIM) begin
            n_drive = NEG_LIM[pidc_pkg::DRV_W-1:0];
        end else begin
            n_drive = sum[pidc_pkg::DRV_W-1:0];
        end
    end

    // settle band and saturating timers
    always_comb begin
        band_hit  = err_mag < {1'b0, r_band};
        set_add   = {1'b0, r_set_tmr} + {{(pidc_pkg::TMR_W+1-pidc_pkg::DT_W){1'b0}}, r_dt};
        band_add  = {1'b0, r_band_tmr} + {{(pidc_pkg::TMR_W+1-pidc_pkg::DT_W){1'b0}}, r_dt};
        n_set_tmr = set_add[pidc_pkg::TMR_W] ? '1 : set_add[pidc_pkg::TMR_W-1:0];
        if (!band_hit) begin
            n_band_tmr = r_band_tmr;
        end else begin
            n_band_tmr = band_add[pidc_pkg::TMR_W] ? '1 : band_add[pidc_pkg::TMR_W-1:0];
        end
    end

    pidc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod[pidc_pkg::DIVD_W-1:0]),
        .i_divisor  (r_dt),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // configuration and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_band       <= '0;
            r_prev_err   <= '0;
            r_integ      <= '0;
            r_set_tmr    <= '0;
            r_band_tmr   <= '0;
            r_last_drive <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pidc_pkg::CFG_GAIN_P:      r_gain_p <= i_cfg_data;
                    pidc_pkg::CFG_GAIN_I:      r_gain_i <= i_cfg_data;
                    pidc_pkg::CFG_GAIN_D:      r_gain_d <= i_cfg_data;
                    pidc_pkg::CFG_SETTLE_BAND: r_band   <= i_cfg_data[pidc_pkg::BAND_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.integ_upd) begin
                r_integ <= n_integ;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (r_cmd_bit == pidc_pkg::CMD_TIMER_RESET) begin
                    r_set_tmr  <= '0;
                    r_band_tmr <= '0;
                end else begin
                    r_prev_err   <= r_err;
                    r_last_drive <= r_drive;
                    r_set_tmr    <= n_set_tmr;
                    r_band_tmr   <= n_band_tmr;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_bit <= i_command;
            r_err     <= i_error;
            r_dt      <= i_delta_t;
        end
        if (i_cmd.mul_sel != pidc_pkg::MUL_NONE) begin
            r_prod <= mul_p;
        end
        if (i_cmd.p_store) begin
            r_p <= n_p;
        end
        if (i_cmd.ilo_store) begin
            r_ilo <= r_prod[pidc_pkg::INT_W-1:0];
        end
        if (i_cmd.i_join) begin
            r_ifull <= {r_prod[pidc_pkg::INT_W-1:0], 32'b0}
                     + {32'b0, r_ilo};
        end
        if (i_cmd.i_cap) begin
            r_i <= n_i;
        end
        if (i_cmd.d_take) begin
            r_d <= n_d;
        end
        if (i_cmd.sum) begin
            r_drive <= n_drive;
        end
        if (i_cmd.commit) begin
            if (r_cmd_bit == pidc_pkg::CMD_TIMER_RESET) begin
                r_o_drive   <= r_last_drive;
                r_o_set     <= '0;
                r_o_band    <= '0;
                r_o_in_band <= 1'b0;
            end else begin
                r_o_drive   <= r_drive;
                r_o_set     <= n_set_tmr;
                r_o_band    <= n_band_tmr;
                r_o_in_band <= band_hit;
            end
        end
    end

    assign o_status.is_timer_reset = (r_cmd_bit == pidc_pkg::CMD_TIMER_RESET);
    assign o_status.div_done       = div_done;
    assign o_status.out_free       = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_drive          = r_o_drive;
    assign o_time_since_set = r_o_set;
    assign o_time_in_band   = r_o_band;
    assign o_in_band        = r_o_in_band;

endmodule

@@ hdl/pidc_ctrl.sv @@
// pidc_ctrl: sequencer that steps the datapath through one update word
// depends on pidc_pkg
module pidc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pidc_pkg::t_dp_status i_status,
    output pidc_pkg::t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL_D   = 4'd1;
    localparam logic [3:0] S_MUL_INC = 4'd2;
    localparam logic [3:0] S_INTEG   = 4'd3;
    localparam logic [3:0] S_P       = 4'd4;
    localparam logic [3:0] S_ILO     = 4'd5;
    localparam logic [3:0] S_IHI     = 4'd6;
    localparam logic [3:0] S_ICAP    = 4'd7;
    localparam logic [3:0] S_WAIT_D  = 4'd8;
    localparam logic [3:0] S_SUM     = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    logic [3:0] r_state, n_state;
    logic       accept;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept) begin
                    n_state = S_MUL_D;
                end
            end
            S_MUL_D: begin
                // a timer reset word skips the arithmetic
                if (i_status.is_timer_reset) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.mul_sel = pidc_pkg::MUL_D;
                    n_state       = S_MUL_INC;
                end
            end
            S_MUL_INC: begin
                o_cmd.div_start = 1'b1;
                o_cmd.mul_sel   = pidc_pkg::MUL_INC;
                n_state         = S_INTEG;
            end
            S_INTEG: begin
                o_cmd.integ_upd = 1'b1;
                o_cmd.mul_sel   = pidc_pkg::MUL_P;
                n_state         = S_P;
            end
            S_P: begin
                o_cmd.p_store = 1'b1;
                o_cmd.mul_sel = pidc_pkg::MUL_ILO;
                n_state       = S_ILO;
            end
            S_ILO: begin
                o_cmd.ilo_store = 1'b1;
                o_cmd.mul_sel   = pidc_pkg::MUL_IHI;
                n_state         = S_IHI;
            end
            S_IHI: begin
                o_cmd.i_join = 1'b1;
                n_state      = S_ICAP;
            end
            S_ICAP: begin
                o_cmd.i_cap = 1'b1;
                n_state     = S_WAIT_D;
            end
            S_WAIT_D: begin
                if (i_status.div_done) begin
                    o_cmd.d_take = 1'b1;
                    n_state      = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/pid_controller_clamped_top.sv @@
// pid_controller_clamped_top: clamped fixed-point pid controller with settle timers
// depends on pidc_pkg, pidc_ctrl, pidc_dp (which holds pidc_div)
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_ready     i_command, i_error, i_delta_t
//  result    out        o_out_valid / i_out_ready   o_drive, o_time_since_set,
//                                                   o_time_in_band, o_in_band
//  config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// an update word's time from accept to result is set by the
// 64-by-16 divider for the derivative term, two quotient bits a cycle
// a timer reset word skips the arithmetic; the next word is taken the cycle after commit
// reset is synchronous active low and clears gains, integral, timers and last error
// a stalled result waits in the output register; a finished word behind it holds
// in the sequencer until the register frees
module pid_controller_clamped_top #(
    parameter int OUTPUT_LIMIT = 1000,
    parameter int FRAC_BITS    = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pidc_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    // input words
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic signed [pidc_pkg::ERR_W-1:0]  i_error,
    input  logic [pidc_pkg::DT_W-1:0]          i_delta_t,
    // result words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [pidc_pkg::DRV_W-1:0]  o_drive,
    output logic [pidc_pkg::TMR_W-1:0]         o_time_since_set,
    output logic [pidc_pkg::TMR_W-1:0]         o_time_in_band,
    output logic                               o_in_band
);

    // clamp bound, used to check the drive where it fits the field
    localparam longint LIM_V    = longint'(OUTPUT_LIMIT) << FRAC_BITS;
    localparam bit     LIM_FITS = LIM_V < (longint'(1) << (pidc_pkg::DRV_W - 1));

    pidc_pkg::t_dp_cmd    dp_cmd;
    pidc_pkg::t_dp_status dp_status;

    // sequencer: one word at a time through the datapath steps
    pidc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // arithmetic, state and output register
    pidc_dp #(
        .OUTPUT_LIMIT (OUTPUT_LIMIT),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_error          (i_error),
        .i_delta_t        (i_delta_t),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_drive          (o_drive),
        .o_time_since_set (o_time_since_set),
        .o_time_in_band   (o_time_in_band),
        .o_in_band        (o_in_band)
    );

    // only one word in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a word is in flight");

    // band timer never passes the set timer
    a_timer_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_time_in_band <= o_time_since_set))
        else $error("band timer above set timer");

    // drive stays inside the clamp bound
    a_drive_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && LIM_FITS) |->
            ((longint'(o_drive) <= LIM_V) && (longint'(o_drive) >= -LIM_V)))
        else $error("drive outside clamp bound");

endmodule
